@@ rtl/eatrm_pkg.sv @@
// eatrm_pkg: shared types, constants and rounding helper for the zxz euler
// angle to rotation matrix pipeline; no dependencies
package eatrm_pkg;

   localparam int AngW  = 16;
   localparam int ElemW = 16;

   localparam logic signed [16:0] Turn    = 17'sd23040;
   localparam logic [14:0]        Quarter = 15'd5760;
   localparam logic [14:0]        Half    = 15'd11520;
   localparam logic [14:0]        ThreeQ  = 15'd17280;
   localparam logic [12:0]        Eighth  = 13'd2880;

   localparam logic [28:0] RadQ40 = 29'd299845282;
   localparam logic [30:0] One    = 31'h4000_0000;

   localparam int SinS [4] = '{37, 36, 35, 33};
   localparam int CosS [4] = '{36, 35, 34, 31};

   localparam logic [30:0] SinM [4] = '{
      31'(((64'd1 << 37) + 64'd71) / 64'd72),
      31'(((64'd1 << 36) + 64'd41) / 64'd42),
      31'(((64'd1 << 35) + 64'd19) / 64'd20),
      31'(((64'd1 << 33) + 64'd5) / 64'd6)};
   localparam logic [30:0] CosM [4] = '{
      31'(((64'd1 << 36) + 64'd55) / 64'd56),
      31'(((64'd1 << 35) + 64'd29) / 64'd30),
      31'(((64'd1 << 34) + 64'd11) / 64'd12),
      31'(((64'd1 << 31) + 64'd1) / 64'd2)};

   localparam logic signed [18:0] ElemMax = 19'sd16384;
   localparam logic signed [18:0] ElemMin = -19'sd16384;

   localparam int SinCosLat = 13;
   localparam int MatrixLat = 6;
   localparam int Lat       = SinCosLat + MatrixLat;

   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      logic [1:0]  quad;
      logic        swap;
   } lane_type;

   typedef struct packed {
      logic signed [31:0] sn;
      logic signed [31:0] cs;
   } trig_type;

   // round to nearest, ties away from zero, by a constant shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int sh);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

@@ rtl/eatrm_sincos.sv @@
// eatrm_sincos: 13-stage sine/cosine lane for one angle in 1/64 degree
// depends on eatrm_pkg
module eatrm_sincos import eatrm_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [AngW-1:0] angle,
   output trig_type               trig
);

   logic [11:0] rr_ff;
   logic [1:0]  quad0_ff;
   logic        swap0_ff;
   lane_type    l1_ff, l2_ff;
   lane_type    la_ff [4];
   lane_type    lb_ff [4];
   logic [30:0] qs_ff [4];
   logic [30:0] qc_ff [4];
   logic [30:0] ts_ff [4];
   logic [30:0] tc_ff [4];
   logic [30:0] s_ff, c_ff;
   lane_type    lf_ff;
   trig_type    trig_ff;

   logic signed [16:0] a_c;
   logic [14:0]        a_u;
   logic [1:0]         quad_c;
   logic [12:0]        r_c;
   logic [14:0]        base_c;
   logic [40:0]        xp_c;
   logic [59:0]        x2p_c;
   logic [30:0]        tsi [4];
   logic [30:0]        tci [4];
   lane_type           li  [4];
   logic [60:0]        ps_c [4];
   logic [60:0]        pc_c [4];
   logic [61:0]        ds_c [4];
   logic [61:0]        dc_c [4];
   logic [60:0]        sp_c;
   logic [30:0]        sn_u, cs_u;

   always_comb begin
      a_c = 17'(angle);
      if (a_c > Turn) a_c = Turn;
      if (a_c < -Turn) a_c = -Turn;
      if (a_c < 0) a_c = a_c + Turn;
      if (a_c >= Turn) a_c = '0;
      a_u = a_c[14:0];
      if (a_u >= ThreeQ) begin
         quad_c = 2'd3; base_c = ThreeQ;
      end else if (a_u >= Half) begin
         quad_c = 2'd2; base_c = Half;
      end else if (a_u >= Quarter) begin
         quad_c = 2'd1; base_c = Quarter;
      end else begin
         quad_c = 2'd0; base_c = '0;
      end
      r_c = 13'(a_u - base_c);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad0_ff <= quad_c;
         swap0_ff <= (r_c > Eighth);
         rr_ff    <= (r_c > Eighth) ? 12'(13'(Quarter) - r_c) : r_c[11:0];
      end
   end

   assign xp_c  = 41'(rr_ff) * 41'(RadQ40) + 41'd512;
   assign x2p_c = 60'(l1_ff.x) * 60'(l1_ff.x) + (60'd1 << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         l1_ff.x    <= xp_c[39:10];
         l1_ff.x2   <= '0;
         l1_ff.quad <= quad0_ff;
         l1_ff.swap <= swap0_ff;
         l2_ff.x    <= l1_ff.x;
         l2_ff.x2   <= x2p_c[59:30];
         l2_ff.quad <= l1_ff.quad;
         l2_ff.swap <= l1_ff.swap;
      end
   end

   // horner steps: multiply and round, then multiply by a reciprocal constant, shift and subtract
   always_comb begin
      tsi[0] = One;
      tci[0] = One;
      li[0]  = l2_ff;
      for (int i = 1; i < 4; i++) begin
         tsi[i] = ts_ff[i-1];
         tci[i] = tc_ff[i-1];
         li[i]  = lb_ff[i-1];
      end
      for (int i = 0; i < 4; i++) begin
         ps_c[i] = 61'(li[i].x2) * 61'(tsi[i]) + (61'd1 << 29);
         pc_c[i] = 61'(li[i].x2) * 61'(tci[i]) + (61'd1 << 29);
         ds_c[i] = (62'(qs_ff[i]) * 62'(SinM[i])) >> SinS[i];
         dc_c[i] = (62'(qc_ff[i]) * 62'(CosM[i])) >> CosS[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            qs_ff[i] <= ps_c[i][60:30];
            qc_ff[i] <= pc_c[i][60:30];
            la_ff[i] <= li[i];
            ts_ff[i] <= One - ds_c[i][30:0];
            tc_ff[i] <= One - dc_c[i][30:0];
            lb_ff[i] <= la_ff[i];
         end
      end
   end

   assign sp_c = 61'(lb_ff[3].x) * 61'(ts_ff[3]) + (61'd1 << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff  <= sp_c[60:30];
         c_ff  <= tc_ff[3];
         lf_ff <= lb_ff[3];
      end
   end

   always_comb begin
      sn_u = lf_ff.swap ? c_ff : s_ff;
      cs_u = lf_ff.swap ? s_ff : c_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         case (lf_ff.quad)
            2'd0: begin
               trig_ff.sn <= 32'(sn_u);  trig_ff.cs <= 32'(cs_u);
            end
            2'd1: begin
               trig_ff.sn <= 32'(cs_u);  trig_ff.cs <= -32'(sn_u);
            end
            2'd2: begin
               trig_ff.sn <= -32'(sn_u); trig_ff.cs <= -32'(cs_u);
            end
            default: begin
               trig_ff.sn <= -32'(cs_u); trig_ff.cs <= 32'(sn_u);
            end
         endcase
      end
   end

   assign trig = trig_ff;

endmodule

@@ rtl/eatrm_matrix.sv @@
// eatrm_matrix: 6-stage product, sum, round and saturate pipeline for the
// nine zxz matrix elements; depends on eatrm_pkg
module eatrm_matrix import eatrm_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  trig_type                phi,
   input  trig_type                the,
   input  trig_type                psi,
   output logic signed [ElemW-1:0] elem [9]
);

   // two-factor terms: cpsi*cphi, spsi*cphi, sthe*sphi, cpsi*sphi,
   // spsi*sphi, sthe*cphi, spsi*sthe, cpsi*sthe
   logic signed [63:0] p0_ff [8];
   logic signed [63:0] p1_ff [8];
   logic signed [63:0] p2_ff [8];
   logic signed [63:0] raw1_ff, raw2_ff;
   logic signed [63:0] t1_ff, t2_ff;
   logic signed [63:0] t1s_ff, t1c_ff, t2s_ff, t2c_ff;
   logic signed [31:0] cthe0_ff, cthe1_ff, cthe2_ff;
   logic signed [31:0] spsi0_ff, cpsi0_ff, spsi1_ff, cpsi1_ff;
   logic signed [63:0] sum_ff [9];
   logic signed [18:0] rq_ff  [9];
   logic signed [ElemW-1:0] out_ff [9];
   logic signed [63:0] rq_c [9];

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff[0] <= 64'(psi.cs) * 64'(phi.cs);
         p0_ff[1] <= 64'(psi.sn) * 64'(phi.cs);
         p0_ff[2] <= 64'(the.sn) * 64'(phi.sn);
         p0_ff[3] <= 64'(psi.cs) * 64'(phi.sn);
         p0_ff[4] <= 64'(psi.sn) * 64'(phi.sn);
         p0_ff[5] <= 64'(the.sn) * 64'(phi.cs);
         p0_ff[6] <= 64'(psi.sn) * 64'(the.sn);
         p0_ff[7] <= 64'(psi.cs) * 64'(the.sn);
         raw1_ff  <= 64'(the.cs) * 64'(phi.sn);
         raw2_ff  <= 64'(the.cs) * 64'(phi.cs);
         cthe0_ff <= the.cs;
         spsi0_ff <= psi.sn;
         cpsi0_ff <= psi.cs;

         p1_ff    <= p0_ff;
         t1_ff    <= rnd_shift(raw1_ff, 30);
         t2_ff    <= rnd_shift(raw2_ff, 30);
         cthe1_ff <= cthe0_ff;
         spsi1_ff <= spsi0_ff;
         cpsi1_ff <= cpsi0_ff;

         p2_ff    <= p1_ff;
         t1s_ff   <= 64'($signed(t1_ff[31:0])) * 64'(spsi1_ff);
         t1c_ff   <= 64'($signed(t1_ff[31:0])) * 64'(cpsi1_ff);
         t2s_ff   <= 64'($signed(t2_ff[31:0])) * 64'(spsi1_ff);
         t2c_ff   <= 64'($signed(t2_ff[31:0])) * 64'(cpsi1_ff);
         cthe2_ff <= cthe1_ff;

         sum_ff[0] <= p2_ff[0] - t1s_ff;
         sum_ff[1] <= -p2_ff[1] - t1c_ff;
         sum_ff[2] <= p2_ff[2];
         sum_ff[3] <= p2_ff[3] + t2s_ff;
         sum_ff[4] <= -p2_ff[4] + t2c_ff;
         sum_ff[5] <= -p2_ff[5];
         sum_ff[6] <= p2_ff[6];
         sum_ff[7] <= p2_ff[7];
         sum_ff[8] <= 64'(cthe2_ff) <<< 30;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rq_c[i] = rnd_shift(sum_ff[i], 46);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            rq_ff[i] <= rq_c[i][18:0];
            if (rq_ff[i] > ElemMax) out_ff[i] <= ElemW'(ElemMax);
            else if (rq_ff[i] < ElemMin) out_ff[i] <= ElemW'(ElemMin);
            else out_ff[i] <= rq_ff[i][ElemW-1:0];
         end
      end
   end

   assign elem = out_ff;

endmodule

@@ rtl/euler_angles_to_rotation_matrix.sv @@
// zxz euler angles to rotation matrix, top level
// one beat per cycle sustained while the result side is not stalled, set by
// the fully pipelined sine/cosine lanes and product stages
// a stalled result holds the whole pipeline; reset clears only the valid bits
// depends on eatrm_pkg, eatrm_sincos, eatrm_matrix
module euler_angles_to_rotation_matrix import eatrm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [AngW-1:0]  req_angle_phi,
   input  logic signed [AngW-1:0]  req_angle_theta,
   input  logic signed [AngW-1:0]  req_angle_psi,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [ElemW-1:0] rsp_m00,
   output logic signed [ElemW-1:0] rsp_m01,
   output logic signed [ElemW-1:0] rsp_m02,
   output logic signed [ElemW-1:0] rsp_m10,
   output logic signed [ElemW-1:0] rsp_m11,
   output logic signed [ElemW-1:0] rsp_m12,
   output logic signed [ElemW-1:0] rsp_m20,
   output logic signed [ElemW-1:0] rsp_m21,
   output logic signed [ElemW-1:0] rsp_m22
);

   logic [Lat-1:0] vld_ff, vld_in;
   logic           en;
   trig_type       phi, the, psi;
   logic signed [ElemW-1:0] elem [9];

   assign en        = !vld_ff[Lat-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[Lat-1];

   assign vld_in = en ? {vld_ff[Lat-2:0], req_valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   eatrm_sincos u_phi (.clock(clock), .en(en), .angle(req_angle_phi),   .trig(phi));
   eatrm_sincos u_the (.clock(clock), .en(en), .angle(req_angle_theta), .trig(the));
   eatrm_sincos u_psi (.clock(clock), .en(en), .angle(req_angle_psi),   .trig(psi));

   eatrm_matrix u_matrix (
      .clock(clock), .en(en), .phi(phi), .the(the), .psi(psi), .elem(elem)
   );

   assign rsp_m00 = elem[0];
   assign rsp_m01 = elem[1];
   assign rsp_m02 = elem[2];
   assign rsp_m10 = elem[3];
   assign rsp_m11 = elem[4];
   assign rsp_m12 = elem[5];
   assign rsp_m20 = elem[6];
   assign rsp_m21 = elem[7];
   assign rsp_m22 = elem[8];

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m22 <= 16'sd16384 && rsp_m22 >= -16'sd16384 &&
                     rsp_m00 <= 16'sd16384 && rsp_m00 >= -16'sd16384))
      else $error("matrix element out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(en) && !$past(reset)) |-> vld_ff == $past(vld_ff))
      else $error("pipeline moved during stall");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
